>>> src/i2cm_pkg.sv
// Package for the I2C master byte engine: command and phase codes,
// engine state type and reset value. No dependencies.
`timescale 1ns / 1ps

package i2cm_pkg;

	localparam logic [2:0] KIND_START = 3'd0;
	localparam logic [2:0] KIND_STOP  = 3'd1;
	localparam logic [2:0] KIND_WRITE = 3'd2;
	localparam logic [2:0] KIND_READ  = 3'd3;
	localparam logic [2:0] KIND_TICK  = 3'd4;

	localparam logic [2:0] PH_IDLE  = 3'd0;
	localparam logic [2:0] PH_START = 3'd1;
	localparam logic [2:0] PH_STOP  = 3'd2;
	localparam logic [2:0] PH_WRITE = 3'd3;
	localparam logic [2:0] PH_READ  = 3'd4;

	localparam logic [4:0] LAST_TICK = 5'd16;
	localparam logic [7:0] MSB_MASK  = 8'h80;

	typedef struct packed {
		logic [2:0] phase;
		logic [4:0] tick;
		logic [7:0] shift;
		logic       ack_flag;
		logic       ack_to_send;
		logic       scl;
		logic       sda;
		logic [7:0] read_hold;
	} state_t;

	localparam state_t STATE_RESET = '{
		phase: PH_IDLE, tick: 5'd0, shift: 8'd0, ack_flag: 1'b0,
		ack_to_send: 1'b0, scl: 1'b1, sda: 1'b1, read_hold: 8'd0
	};

	typedef struct packed {
		logic done;
		logic rejected;
	} flags_t;

endpackage

>>> src/i2c_master_byte_engine.sv
// I2C master byte engine; each accepted beat gives a registered result beat.
// Throughput one beat per cycle while m_tready is high; the result register is
// freed when taken, so a new beat is accepted in the cycle a result is taken.
// Reset (arst_n low, asynchronous): idle, SCL and SDA released, flags and
// read byte zero, no result pending. Depends on i2cm_pkg and i2cm_step.
`timescale 1ns / 1ps

module i2c_master_byte_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // write_data[7:0], rd_ack[8], sda_sample[9], zero
	input  logic [2:0]  s_tuser,  // kind[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // scl_release, sda_release, busy_res, done_res,
	                              // rejected, ack_ok, read_byte[13:6], zero
);

	i2cm_pkg::state_t state_q;
	i2cm_pkg::state_t state_nxt;
	i2cm_pkg::flags_t flags;
	logic [15:0]      res_q;
	logic             res_valid_q;
	logic             accept;

	assign s_tready = ~res_valid_q | m_tready;
	assign accept   = s_tvalid & s_tready;

	i2cm_step u_step (
		.cur        (state_q),
		.kind       (s_tuser),
		.write_data (s_tdata[7:0]),
		.rd_ack     (s_tdata[8]),
		.sda_sample (s_tdata[9]),
		.nxt        (state_nxt),
		.flags      (flags)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= i2cm_pkg::STATE_RESET;
			res_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				state_q     <= state_nxt;
				res_valid_q <= 1'b1;
			end else if (m_tready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= {2'b00, state_nxt.read_hold, state_nxt.ack_flag, flags.rejected,
				flags.done, state_nxt.phase != i2cm_pkg::PH_IDLE,
				state_nxt.sda, state_nxt.scl};
		end
	end

	assign m_tvalid = res_valid_q;
	assign m_tdata  = res_q;

endmodule

>>> src/i2cm_step.sv
// Next-state logic of the I2C master byte engine for one beat.
// Depends on i2cm_pkg.
`timescale 1ns / 1ps

module i2cm_step (
	input  i2cm_pkg::state_t cur,
	input  logic [2:0]       kind,
	input  logic [7:0]       write_data,
	input  logic             rd_ack,
	input  logic             sda_sample,
	output i2cm_pkg::state_t nxt,
	output i2cm_pkg::flags_t flags
);

	logic       busy;
	logic       even;
	logic [7:0] shl;
	logic [4:0] tick_inc;

	assign busy     = cur.phase != i2cm_pkg::PH_IDLE;
	assign even     = ~cur.tick[0];
	assign shl      = {cur.shift[6:0], 1'b0};
	assign tick_inc = cur.tick + 5'd1;

	always_comb begin
		nxt   = cur;
		flags = '0;
		case (kind) inside
			i2cm_pkg::KIND_START, i2cm_pkg::KIND_STOP,
			i2cm_pkg::KIND_WRITE, i2cm_pkg::KIND_READ: begin
				if (busy) begin
					flags.rejected = 1'b1;
				end else begin
					nxt.tick = 5'd0;
					nxt.scl  = 1'b1;
					unique case (kind)
						i2cm_pkg::KIND_START: begin
							nxt.phase = i2cm_pkg::PH_START;
							nxt.sda   = 1'b1;
						end
						i2cm_pkg::KIND_STOP: begin
							nxt.phase = i2cm_pkg::PH_STOP;
							nxt.sda   = 1'b0;
						end
						i2cm_pkg::KIND_WRITE: begin
							nxt.phase = i2cm_pkg::PH_WRITE;
							nxt.shift = write_data;
							nxt.sda   = (write_data & i2cm_pkg::MSB_MASK) != 8'd0;
						end
						default: begin
							nxt.phase       = i2cm_pkg::PH_READ;
							nxt.shift       = 8'd0;
							nxt.ack_to_send = rd_ack;
							nxt.sda         = 1'b1;
						end
					endcase
				end
			end
			i2cm_pkg::KIND_TICK: begin
				if (busy) begin
					unique case (cur.phase)
						i2cm_pkg::PH_START: begin
							if (cur.tick == 5'd0) begin
								nxt.sda  = 1'b0;
								nxt.tick = 5'd1;
							end else begin
								nxt.scl    = 1'b0;
								nxt.phase  = i2cm_pkg::PH_IDLE;
								nxt.tick   = 5'd0;
								flags.done = 1'b1;
							end
						end
						i2cm_pkg::PH_STOP: begin
							if (cur.tick == 5'd0) begin
								nxt.sda  = 1'b1;
								nxt.tick = 5'd1;
							end else begin
								nxt.phase  = i2cm_pkg::PH_IDLE;
								nxt.tick   = 5'd0;
								flags.done = 1'b1;
							end
						end
						i2cm_pkg::PH_WRITE: begin
							if (cur.tick >= i2cm_pkg::LAST_TICK) begin
								nxt.ack_flag = ~sda_sample;
								nxt.scl      = 1'b0;
								nxt.phase    = i2cm_pkg::PH_IDLE;
								nxt.tick     = 5'd0;
								flags.done   = 1'b1;
							end else begin
								if (even) begin
									nxt.scl = 1'b0;
								end else begin
									nxt.shift = shl;
									nxt.sda   = (cur.tick == i2cm_pkg::LAST_TICK - 5'd1) ?
										1'b1 : shl[7];
									nxt.scl   = 1'b1;
								end
								nxt.tick = tick_inc;
							end
						end
						i2cm_pkg::PH_READ: begin
							if (cur.tick >= i2cm_pkg::LAST_TICK) begin
								nxt.scl       = 1'b0;
								nxt.sda       = 1'b1;
								nxt.read_hold = cur.shift;
								nxt.phase     = i2cm_pkg::PH_IDLE;
								nxt.tick      = 5'd0;
								flags.done    = 1'b1;
							end else begin
								if (even) begin
									nxt.shift = {cur.shift[6:0], sda_sample};
									nxt.scl   = 1'b0;
								end else begin
									if (cur.tick == i2cm_pkg::LAST_TICK - 5'd1) begin
										nxt.sda = ~cur.ack_to_send;
									end
									nxt.scl = 1'b1;
								end
								nxt.tick = tick_inc;
							end
						end
						default: begin
							nxt.phase = i2cm_pkg::PH_IDLE;
							nxt.tick  = 5'd0;
						end
					endcase
				end
			end
			default: ;
		endcase
	end

endmodule

>>> src/i2cm_checker.sv
// Port-level checks for the I2C master byte engine, bound to the top level.
// Depends on i2c_master_byte_engine ports only.
`timescale 1ns / 1ps

module i2cm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty result register");

	a_reject_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[4] |-> m_tdata[2] && !m_tdata[3])
		else $error("rejected beat not busy or marked done");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[3] |-> !m_tdata[2])
		else $error("done beat still busy");

endmodule

bind i2c_master_byte_engine i2cm_checker u_i2cm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
